/* sv/sstw_pkg.sv */
// Shared types, constants and helper functions of the two-wire segment display writer.
package sstw_pkg;

    // Function codes carried in the input item's tuser field.
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_SHOW   = 2'd1;
    localparam logic [1:0] FUNC_BRIGHT = 2'd2;

    // Bytes of the display protocol.
    localparam logic [7:0] CMD_DATA_WRITE = 8'h40;
    localparam logic [7:0] CMD_ADDR_FIRST = 8'hc0;
    localparam logic [7:0] CMD_DISP_OFF   = 8'h80;
    localparam logic [7:0] CMD_DISP_ON    = 8'h88;
    localparam logic [7:0] SEG_COLON      = 8'h80;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3a;

    localparam logic [3:0] LEVEL_MAX      = 4'd8;
    localparam logic [7:0] WAIT_TICKS_RST = 8'd5;

    // Longest frame: data-write command, address command and five digit bytes.
    localparam int FRAME_DEPTH = 7;
    localparam int NUM_CHARS   = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_SHOW,
        KIND_BRIGHT,
        KIND_NONE
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_S0, PH_S1, PH_S2,
        PH_B0, PH_B1, PH_B2,
        PH_A0, PH_A1, PH_A2,
        PH_T0, PH_T1, PH_T2, PH_T3
    } t_phase;

    // One classified item, ready for the sequencer.
    typedef struct packed {
        t_kind                      kind;
        logic [2:0]                 count;
        logic [FRAME_DEPTH-1:0][7:0] frame;
    } t_cmd;

    // Handshake between the queue and the sequencer.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qout;

    // Result item, packed so that clk_pin lands in bit 0.
    typedef struct packed {
        logic dropped;
        logic busy;
        logic dio;
        logic clk;
    } t_result;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    endfunction

endpackage

/* sv/sstw_front.sv */
// Front end: classifies input items and builds the byte list of a frame.
module sstw_front (
    input  logic              [1:0] i_func,
    input  logic              [7:0] i_char_a,
    input  logic              [7:0] i_char_b,
    input  logic              [7:0] i_char_c,
    input  logic              [7:0] i_char_d,
    input  logic              [7:0] i_char_e,
    input  logic              [3:0] i_level,
    output sstw_pkg::t_cmd          o_cmd
);

    logic [sstw_pkg::NUM_CHARS-1:0][7:0] chars;
    logic [3:0] lvl;
    logic [2:0] lvl_m1;
    logic [2:0] slot;

    assign chars = {i_char_e, i_char_d, i_char_c, i_char_b, i_char_a};

    always_comb begin
        o_cmd.kind  = sstw_pkg::KIND_NONE;
        o_cmd.count = 3'd0;
        o_cmd.frame = '0;
        lvl         = (i_level > sstw_pkg::LEVEL_MAX) ? sstw_pkg::LEVEL_MAX : i_level;
        lvl_m1      = 3'(lvl - 4'd1);
        slot        = 3'd2;

        unique case (i_func)
            sstw_pkg::FUNC_TICK: begin
                o_cmd.kind = sstw_pkg::KIND_TICK;
            end
            sstw_pkg::FUNC_SHOW: begin
                o_cmd.kind     = sstw_pkg::KIND_SHOW;
                o_cmd.frame[0] = sstw_pkg::CMD_DATA_WRITE;
                o_cmd.frame[1] = sstw_pkg::CMD_ADDR_FIRST;
                for (int i = 0; i < sstw_pkg::NUM_CHARS; i++) begin
                    if (i == 2 && chars[i] == sstw_pkg::CHAR_COLON) begin
                        // The colon lights on the second digit, only after two digits.
                        if (sstw_pkg::is_digit(chars[0]) && sstw_pkg::is_digit(chars[1])) begin
                            o_cmd.frame[3] = o_cmd.frame[3] | sstw_pkg::SEG_COLON;
                        end
                    end else if (sstw_pkg::is_digit(chars[i])) begin
                        o_cmd.frame[slot] = sstw_pkg::seg_of(chars[i][3:0]);
                        slot              = slot + 3'd1;
                    end
                end
                o_cmd.count = slot;
            end
            sstw_pkg::FUNC_BRIGHT: begin
                o_cmd.kind  = sstw_pkg::KIND_BRIGHT;
                o_cmd.count = 3'd1;
                if (i_level == 4'd0) begin
                    o_cmd.frame[0] = sstw_pkg::CMD_DISP_OFF;
                end else begin
                    o_cmd.frame[0] = sstw_pkg::CMD_DISP_ON | {5'd0, lvl_m1};
                end
            end
            default: begin
                o_cmd.kind = sstw_pkg::KIND_NONE;
            end
        endcase
    end

endmodule

/* sv/sstw_queue.sv */
// Short command queue between the front end and the pin sequencer.
module sstw_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sstw_pkg::t_cmd        i_cmd,
    output logic                  o_full,
    input  logic                  i_pop,
    output sstw_pkg::t_qout       o_head
);

    sstw_pkg::t_cmd                    r_mem [sstw_pkg::QUEUE_DEPTH];
    logic [sstw_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [sstw_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [sstw_pkg::QCNT_W-1:0]       r_count;
    logic                              do_push;
    logic                              do_pop;

    assign o_full       = (r_count == sstw_pkg::QCNT_W'(sstw_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == sstw_pkg::QPTR_W'(sstw_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == sstw_pkg::QPTR_W'(sstw_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* sv/sstw_back.sv */
// Back end: the pin sequencer, the delay counter and the result register.
module sstw_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sstw_pkg::t_qout       i_head,
    output logic                  o_pop,
    input  logic                  i_cfg_valid,
    input  logic            [7:0] i_cfg_data,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output sstw_pkg::t_result     o_res
);

    sstw_pkg::t_phase  r_phase, n_phase;
    logic [7:0]        r_frame [sstw_pkg::FRAME_DEPTH];
    logic [2:0]        r_count;
    logic [2:0]        r_byte_pos, n_byte_pos;
    logic [2:0]        r_bit_pos, n_bit_pos;
    logic [7:0]        r_wait_left, n_wait_left;
    logic [7:0]        r_wait_ticks;
    logic              r_clk, n_clk;
    logic              r_dio, n_dio;
    logic              r_res_valid;
    sstw_pkg::t_result r_res;

    logic       step;
    logic       busy;
    logic       is_tick;
    logic       is_req;
    logic       advance;
    logic       start;
    logic       more_bytes;
    logic [7:0] cur_byte;

    assign o_pop   = !r_res_valid || i_res_ready;
    assign step    = i_head.valid && o_pop;
    assign busy    = (r_phase != sstw_pkg::PH_IDLE);
    assign is_tick = (i_head.cmd.kind == sstw_pkg::KIND_TICK);
    assign is_req  = (i_head.cmd.kind == sstw_pkg::KIND_SHOW)
                  || (i_head.cmd.kind == sstw_pkg::KIND_BRIGHT);
    assign advance = step && is_tick && busy && (r_wait_left == 8'd0);
    assign start   = step && is_req && !busy;

    assign cur_byte   = r_frame[r_byte_pos];
    assign more_bytes = ({1'b0, r_byte_pos} + 4'd1) < {1'b0, r_count};

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (start) begin
            n_phase = sstw_pkg::PH_S0;
        end else if (advance) begin
            unique case (r_phase)
                sstw_pkg::PH_S0: n_phase = sstw_pkg::PH_S1;
                sstw_pkg::PH_S1: n_phase = sstw_pkg::PH_S2;
                sstw_pkg::PH_S2: n_phase = sstw_pkg::PH_B0;
                sstw_pkg::PH_B0: n_phase = sstw_pkg::PH_B1;
                sstw_pkg::PH_B1: n_phase = sstw_pkg::PH_B2;
                sstw_pkg::PH_B2: n_phase = (r_bit_pos == 3'd7) ? sstw_pkg::PH_A0
                                                                : sstw_pkg::PH_B0;
                sstw_pkg::PH_A0: n_phase = sstw_pkg::PH_A1;
                sstw_pkg::PH_A1: n_phase = sstw_pkg::PH_A2;
                sstw_pkg::PH_A2: n_phase = more_bytes ? sstw_pkg::PH_B0 : sstw_pkg::PH_T0;
                sstw_pkg::PH_T0: n_phase = sstw_pkg::PH_T1;
                sstw_pkg::PH_T1: n_phase = sstw_pkg::PH_T2;
                sstw_pkg::PH_T2: n_phase = sstw_pkg::PH_T3;
                sstw_pkg::PH_T3: n_phase = sstw_pkg::PH_IDLE;
                default:         n_phase = sstw_pkg::PH_IDLE;
            endcase
        end
    end

    // Pin levels, position counters and the delay counter.
    always_comb begin
        n_clk       = r_clk;
        n_dio       = r_dio;
        n_byte_pos  = r_byte_pos;
        n_bit_pos   = r_bit_pos;
        n_wait_left = r_wait_left;
        if (start) begin
            n_byte_pos  = 3'd0;
            n_bit_pos   = 3'd0;
            n_wait_left = 8'd0;
        end else if (step && is_tick && busy && r_wait_left != 8'd0) begin
            n_wait_left = r_wait_left - 8'd1;
        end else if (advance) begin
            unique case (r_phase)
                sstw_pkg::PH_S0: n_dio = 1'b1;
                sstw_pkg::PH_S1: begin
                    n_clk       = 1'b1;
                    n_wait_left = r_wait_ticks;
                end
                sstw_pkg::PH_S2: begin
                    n_dio      = 1'b0;
                    n_byte_pos = 3'd0;
                    n_bit_pos  = 3'd0;
                end
                sstw_pkg::PH_B0: n_clk = 1'b0;
                sstw_pkg::PH_B1: begin
                    n_dio       = cur_byte[r_bit_pos];
                    n_wait_left = r_wait_ticks;
                end
                sstw_pkg::PH_B2: begin
                    n_clk       = 1'b1;
                    n_wait_left = r_wait_ticks;
                    n_bit_pos   = (r_bit_pos == 3'd7) ? 3'd0 : r_bit_pos + 3'd1;
                end
                sstw_pkg::PH_A0: begin
                    n_clk       = 1'b0;
                    n_wait_left = r_wait_ticks;
                end
                sstw_pkg::PH_A1: begin
                    n_clk       = 1'b1;
                    n_wait_left = r_wait_ticks;
                end
                sstw_pkg::PH_A2: begin
                    n_clk = 1'b0;
                    if (more_bytes) begin
                        n_byte_pos = r_byte_pos + 3'd1;
                    end
                end
                sstw_pkg::PH_T0: begin
                    n_clk       = 1'b0;
                    n_wait_left = r_wait_ticks;
                end
                sstw_pkg::PH_T1: begin
                    n_dio       = 1'b0;
                    n_wait_left = r_wait_ticks;
                end
                sstw_pkg::PH_T2: begin
                    n_clk       = 1'b1;
                    n_wait_left = r_wait_ticks;
                end
                sstw_pkg::PH_T3: n_dio = 1'b1;
                default: begin
                    n_clk = r_clk;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= sstw_pkg::PH_IDLE;
            r_count      <= 3'd0;
            r_byte_pos   <= 3'd0;
            r_bit_pos    <= 3'd0;
            r_wait_left  <= 8'd0;
            r_wait_ticks <= sstw_pkg::WAIT_TICKS_RST;
            r_clk        <= 1'b0;
            r_dio        <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_byte_pos  <= n_byte_pos;
            r_bit_pos   <= n_bit_pos;
            r_wait_left <= n_wait_left;
            r_clk       <= n_clk;
            r_dio       <= n_dio;
            if (start) begin
                r_count <= i_head.cmd.count;
            end
            if (i_cfg_valid) begin
                r_wait_ticks <= i_cfg_data;
            end
            if (step) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            for (int i = 0; i < sstw_pkg::FRAME_DEPTH; i++) begin
                r_frame[i] <= i_head.cmd.frame[i];
            end
        end
        if (step) begin
            r_res.clk     <= n_clk;
            r_res.dio     <= n_dio;
            r_res.busy    <= (n_phase != sstw_pkg::PH_IDLE);
            r_res.dropped <= step && is_req && busy;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* sv/seven_segment_two_wire_writer.sv */
// Top level of the two-wire seven-segment display writer.
//
// This block drives the clock and data lines of a two-wire seven-segment
// display controller. Every input item yields exactly one result item that
// reports the pin levels, whether a frame is in flight, and whether the item
// was a request that got dropped. A tick item (func 0) moves the pin sequence
// one step forward, or counts down the hold delay set by the wait_ticks
// register. A show request (func 1) turns five characters into segment bytes,
// skipping anything that is not a decimal digit, and queues the frame 0x40,
// 0xC0 and those bytes; a colon as the third character lights the colon bit
// of the second digit when the first two characters are digits. A brightness
// request (func 2) sends 0x80 for level 0 or 0x88 with the level minus one,
// levels above 8 counting as 8. Requests that arrive while a frame is being
// sent are dropped and flagged. A front end classifies items and builds the
// frame bytes, a two-entry queue decouples it from the pin sequencer in the
// back end, and the result sits in an output register. The block takes one
// item per clock cycle while the queue has room. An accepted item is written
// into the queue and passes on to the output register once that register is
// free; a stall on the output side is absorbed by the queue before
// s_axis_tready falls. The wait_ticks register may only be written while no
// item is in flight; its write port is always ready.
module seven_segment_two_wire_writer (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // From bit 0: char_a[7:0], char_b[7:0], char_c[7:0], char_d[7:0],
    // char_e[7:0], level[3:0], then four zero bits.
    input  logic [47:0] s_axis_tdata,
    // From bit 0: func[1:0].
    input  logic  [1:0] s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // From bit 0: clk_pin, dio_pin, busy_res, dropped, then four zero bits.
    output logic  [7:0] m_axis_tdata,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    // The wait_ticks register.
    input  logic  [7:0] i_cfg_data
);

    sstw_pkg::t_cmd    front_cmd;
    sstw_pkg::t_qout   q_head;
    sstw_pkg::t_result res;
    logic              q_full;
    logic              q_pop;

    sstw_front u_front (
        .i_func   (s_axis_tuser),
        .i_char_a (s_axis_tdata[7:0]),
        .i_char_b (s_axis_tdata[15:8]),
        .i_char_c (s_axis_tdata[23:16]),
        .i_char_d (s_axis_tdata[31:24]),
        .i_char_e (s_axis_tdata[39:32]),
        .i_level  (s_axis_tdata[43:40]),
        .o_cmd    (front_cmd)
    );

    sstw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    sstw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign s_axis_tready = !q_full;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tdata  = {4'd0, res};

endmodule

/* sv/sstw_checker.sv */
// Port-level checker for the two-wire display writer, bound to the top level.
module sstw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic  [7:0] m_axis_tdata
);

    // A dropped request can only be reported while a frame is in flight.
    a_dropped_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[2])
        else $error("dropped item reported while not busy");

    // With the output register empty the queue always has room.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // An input item accepted while the output register is empty is followed
    // by a valid result once it has reached the output register through the queue.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
        else $error("result missing two cycles after an item entered an idle block");

endmodule

bind seven_segment_two_wire_writer sstw_checker u_sstw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/pin_sequence_checker.sv */
// Watches the segment display writer's channels, predicts each result item and compares.
module pin_sequence_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [47:0] i_in_data,
    input  logic  [1:0] i_in_func,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic  [7:0] i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic  [7:0] i_cfg_data,
    input  logic        i_end,
    output int          o_fail_count,
    output int          o_results,
    output int          o_frames,
    output int          o_dropped
);
    import sstw_pkg::*;

    // Segment patterns of the digits 0 to 9, digit 0 in the lowest byte.
    localparam logic [79:0] SEG_ROM = {8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d,
                                       8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f};

    logic [7:0] hold_ticks;
    logic [7:0] frame_bytes [6];
    logic [2:0] frame_len;
    logic [2:0] byte_idx;
    logic [2:0] bit_idx;
    t_phase     phase;
    logic [7:0] hold_left;
    logic       clk_lvl;
    logic       dio_lvl;
    logic       with_lead;
    logic       end_seen;
    t_result    pin_levels_q [$];

    function automatic logic [7:0] wire_byte();
        int p;
        p = byte_idx;
        if (with_lead) begin
            if (p == 0) return CMD_DATA_WRITE;
            p = p - 1;
        end
        return (p < 6) ? frame_bytes[p] : 8'h00;
    endfunction

    task automatic hold();
        hold_left = hold_ticks;
    endtask

    // One pin step of the sequencer.
    task automatic advance_pins();
        logic [7:0] cur;
        case (phase)
            PH_S0: begin dio_lvl = 1'b1; phase = PH_S1; end
            PH_S1: begin clk_lvl = 1'b1; hold(); phase = PH_S2; end
            PH_S2: begin
                dio_lvl = 1'b0; byte_idx = '0; bit_idx = '0; phase = PH_B0;
            end
            PH_B0: begin clk_lvl = 1'b0; phase = PH_B1; end
            PH_B1: begin
                cur = wire_byte();
                dio_lvl = cur[bit_idx]; hold(); phase = PH_B2;
            end
            PH_B2: begin
                clk_lvl = 1'b1; hold();
                if (bit_idx == 3'd7) begin
                    bit_idx = '0; phase = PH_A0;
                end else begin
                    bit_idx = bit_idx + 3'd1; phase = PH_B0;
                end
            end
            PH_A0: begin clk_lvl = 1'b0; hold(); phase = PH_A1; end
            PH_A1: begin clk_lvl = 1'b1; hold(); phase = PH_A2; end
            PH_A2: begin
                clk_lvl = 1'b0;
                if (int'(byte_idx) + 1 < int'(frame_len)) begin
                    byte_idx = byte_idx + 3'd1; phase = PH_B0;
                end else begin
                    phase = PH_T0;
                end
            end
            PH_T0: begin clk_lvl = 1'b0; hold(); phase = PH_T1; end
            PH_T1: begin dio_lvl = 1'b0; hold(); phase = PH_T2; end
            PH_T2: begin clk_lvl = 1'b1; hold(); phase = PH_T3; end
            PH_T3: begin dio_lvl = 1'b1; phase = PH_IDLE; end
            default: phase = PH_IDLE;
        endcase
    endtask

    task automatic predict_pins(input logic [1:0] fn, input logic [47:0] data);
        t_result    res;
        logic [7:0] ch [5];
        logic       lead_nums;
        logic [3:0] lvl;
        int         n;
        int         i;
        res = '0;
        case (fn)
            FUNC_TICK: begin
                if (phase != PH_IDLE) begin
                    if (hold_left != 8'd0) hold_left = hold_left - 8'd1;
                    else advance_pins();
                end
            end
            FUNC_SHOW, FUNC_BRIGHT: begin
                if (phase != PH_IDLE) begin
                    res.dropped = 1'b1;
                    o_dropped++;
                end else begin
                    if (fn == FUNC_SHOW) begin
                        for (i = 0; i < NUM_CHARS; i++) ch[i] = data[8*i +: 8];
                        lead_nums = (ch[0] >= CHAR_ZERO) && (ch[0] <= CHAR_NINE) &&
                                    (ch[1] >= CHAR_ZERO) && (ch[1] <= CHAR_NINE);
                        frame_bytes[0] = CMD_ADDR_FIRST;
                        n = 1;
                        for (i = 0; i < NUM_CHARS; i++) begin
                            if (i == 2 && ch[i] == CHAR_COLON) begin
                                // The colon lights bit 7 of the second digit byte.
                                if (lead_nums) frame_bytes[2] = frame_bytes[2] | SEG_COLON;
                            end else if (ch[i] >= CHAR_ZERO && ch[i] <= CHAR_NINE && n < 6) begin
                                frame_bytes[n] = SEG_ROM[8*int'(ch[i] - CHAR_ZERO) +: 8];
                                n++;
                            end
                        end
                        with_lead = 1'b1;
                        frame_len = 3'(n + 1);
                    end else begin
                        lvl = data[43:40];
                        if (lvl == 4'd0) begin
                            frame_bytes[0] = CMD_DISP_OFF;
                        end else begin
                            if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
                            frame_bytes[0] = CMD_DISP_ON | {5'd0, 3'(lvl - 4'd1)};
                        end
                        with_lead = 1'b0;
                        frame_len = 3'd1;
                    end
                    byte_idx = '0;
                    bit_idx = '0;
                    hold_left = '0;
                    phase = PH_S0;
                    o_frames++;
                end
            end
            default: ;
        endcase
        res.clk = clk_lvl;
        res.dio = dio_lvl;
        res.busy = (phase != PH_IDLE);
        pin_levels_q.push_back(res);
    endtask

    task automatic check_result(input logic [7:0] raw);
        t_result got;
        t_result want;
        got = t_result'(raw[3:0]);
        o_results++;
        if (pin_levels_q.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("Result %0d arrived with no prediction waiting: %h", o_results, raw);
        end else begin
            want = pin_levels_q.pop_front();
            if (got.clk !== want.clk || got.dio !== want.dio || got.busy !== want.busy ||
                got.dropped !== want.dropped || raw[7:4] !== 4'd0) begin
                o_fail_count++;
                if (o_fail_count <= 10) begin
                    $display("Result %0d mismatch: expected clk=%b dio=%b busy=%b dropped=%b",
                             o_results, want.clk, want.dio, want.busy, want.dropped);
                    $display("    got clk=%b dio=%b busy=%b dropped=%b pad=%h",
                             got.clk, got.dio, got.busy, got.dropped, raw[7:4]);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_ticks = WAIT_TICKS_RST;
            frame_len = '0;
            byte_idx = '0;
            bit_idx = '0;
            phase = PH_IDLE;
            hold_left = '0;
            clk_lvl = 1'b0;
            dio_lvl = 1'b0;
            with_lead = 1'b0;
            end_seen = 1'b0;
            pin_levels_q.delete();
            o_fail_count = 0;
            o_results = 0;
            o_frames = 0;
            o_dropped = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) hold_ticks = i_cfg_data;
            if (i_in_valid && i_in_ready) predict_pins(i_in_func, i_in_data);
            if (i_out_valid && i_out_ready) check_result(i_out_data);
            if (i_end && !end_seen) begin
                end_seen = 1'b1;
                if (pin_levels_q.size() != 0) begin
                    o_fail_count += pin_levels_q.size();
                    $display("%0d predicted results never arrived", pin_levels_q.size());
                end
            end
        end
    end

endmodule

/* tb/seven_segment_two_wire_writer_test.sv */
// Test top of the segment display writer: clock, reset, stimulus and verdict.
module seven_segment_two_wire_writer_test;
    import sstw_pkg::*;

    // Function code that the block has no use for; it must pass as a no-op.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    // The run is cut off here.
    localparam int CYCLE_LIMIT = 400000;
    // Length of the one long stall on the result side.
    localparam int LONG_HOLD = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // From bit 0: char_a, char_b, char_c, char_d, char_e, level[3:0], four zero bits.
    logic [47:0] s_axis_tdata;
    // From bit 0: func[1:0].
    logic  [1:0] s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // From bit 0: clk_pin, dio_pin, busy_res, dropped, four zero bits.
    logic  [7:0] m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic  [7:0] i_cfg_data;

    logic        idle_on;
    logic        hold_req;
    logic        hold_done;
    logic        end_check;
    int          cur_wait;
    int          items_sent;
    int          items_taken;
    int          results_seen;
    int          cycles;
    int          fail_count;
    int          results_checked;
    int          frames_started;
    int          requests_dropped;

    seven_segment_two_wire_writer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    pin_sequence_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_func    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_end        (end_check),
        .o_fail_count (fail_count),
        .o_results    (results_checked),
        .o_frames     (frames_started),
        .o_dropped    (requests_dropped)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Handshake counts, so that the stimulus can wait for the block to drain.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) items_taken <= items_taken + 1;
            if (m_axis_tvalid && m_axis_tready) results_seen <= results_seen + 1;
        end
    end

    // Result side. Ready is decided at each falling edge for the cycle ahead.
    // Short random stalls while idling is on, and one long stall on request so
    // that the internal queue fills and input ready drops.
    initial begin
        m_axis_tready = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Offer one item and wait until it is accepted. Valid stays high on
    // return, so back-to-back items keep it high unless idling puts a gap in.
    task automatic send_item(input logic [1:0] fn, input logic [47:0] data);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            s_axis_tdata = {$urandom, $urandom};
            s_axis_tuser = 2'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = fn;
        s_axis_tdata = data;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Ticks ignore the data field, so it carries noise.
    task automatic tick_once();
        send_item(FUNC_TICK, {$urandom, $urandom});
    endtask

    // Ticks needed to run a whole frame at the given hold setting: 7 + 27 steps
    // per byte, and 4 + 18 hold points per byte that each cost w further ticks.
    function automatic int frame_ticks(input logic [1:0] fn, input logic [47:0] d,
                                       input int w);
        int nb;
        int i;
        nb = 1;
        if (fn == FUNC_SHOW) begin
            nb = 2;
            for (i = 0; i < NUM_CHARS; i++)
                if (d[8*i +: 8] >= CHAR_ZERO && d[8*i +: 8] <= CHAR_NINE) nb++;
        end
        return 7 + 27 * nb + (4 + 18 * nb) * w;
    endfunction

    function automatic logic [47:0] pack_item(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c, input logic [7:0] d,
                                              input logic [7:0] e, input logic [3:0] lvl);
        return {4'd0, lvl, e, d, c, b, a};
    endfunction

    // Mostly clock-like text with a colon, some mixed text near the digit
    // range, and some raw bytes.
    function automatic logic [39:0] random_text();
        logic [39:0] t;
        int          mode;
        int          pick;
        int          i;
        mode = $urandom_range(0, 9);
        for (i = 0; i < NUM_CHARS; i++) begin
            pick = $urandom_range(0, 3);
            if (mode < 6) begin
                t[8*i +: 8] = (i == 2 && pick != 0) ? CHAR_COLON
                                                    : CHAR_ZERO + 8'($urandom_range(0, 9));
            end else if (mode < 8) begin
                case (pick)
                    0: t[8*i +: 8] = CHAR_ZERO + 8'($urandom_range(0, 9));
                    1: t[8*i +: 8] = CHAR_COLON;
                    2: t[8*i +: 8] = $urandom_range(0, 1) ? CHAR_ZERO - 8'd1 : CHAR_NINE + 8'd2;
                    default: t[8*i +: 8] = 8'($urandom);
                endcase
            end else begin
                t[8*i +: 8] = 8'($urandom);
            end
        end
        return t;
    endfunction

    // A request followed by exactly the ticks that carry its frame to the end.
    task automatic request_frame(input logic [1:0] fn, input logic [47:0] data);
        send_item(fn, data);
        repeat (frame_ticks(fn, data, cur_wait)) tick_once();
    endtask

    // Stop offering and wait until every result is back, plus a short margin.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        @(posedge i_clk);
        while (results_seen != items_taken) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_wait_ticks(input logic [7:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        cur_wait = value;
    endtask

    // Random mix of frames. Most frames get all their ticks; some are cut
    // short so that the next request lands while busy, and now and then a
    // request is pushed into the middle of a frame.
    task automatic run_mixed(input int budget);
        int          used;
        int          k;
        int          full;
        int          pick;
        logic [1:0]  fn;
        logic [47:0] d;
        used = 0;
        while (used < budget) begin
            pick = $urandom_range(0, 99);
            d = {4'd0, 4'($urandom_range(0, 15)), random_text()};
            if (pick < 55) fn = FUNC_SHOW;
            else if (pick < 85) fn = FUNC_BRIGHT;
            else if (pick < 90) fn = FUNC_UNUSED;
            else fn = FUNC_TICK;
            send_item(fn, d);
            used++;
            if (fn == FUNC_SHOW || fn == FUNC_BRIGHT) begin
                full = frame_ticks(fn, d, cur_wait);
                if ($urandom_range(0, 4) == 0) k = $urandom_range(1, full);
                else k = full + $urandom_range(0, 2);
                if (k > budget - used + 2) k = budget - used + 2;
                repeat (k) begin
                    if ($urandom_range(0, 39) == 0) begin
                        send_item($urandom_range(0, 1) ? FUNC_SHOW : FUNC_BRIGHT,
                                  {4'd0, 4'($urandom), random_text()});
                        used++;
                    end
                    tick_once();
                    used++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FUNC_TICK;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        end_check = 1'b0;
        cur_wait = WAIT_TICKS_RST;
        items_sent = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. A brightness frame first runs at the reset hold
        // setting, with the level above 8 that must saturate.
        request_frame(FUNC_BRIGHT, pack_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd15));
        write_wait_ticks(8'd0);
        // A tick while idle and the unused code change nothing.
        tick_once();
        send_item(FUNC_UNUSED, '1);
        // Clock text with the colon, five digits, a colon that must be
        // ignored because the first character is a letter, characters just
        // outside the digit range, and text without any digit at all.
        request_frame(FUNC_SHOW, pack_item("1", "2", ":", "3", "4", 4'd0));
        request_frame(FUNC_SHOW, pack_item("9", "8", "7", "6", "5", 4'd15));
        request_frame(FUNC_SHOW, pack_item("a", "1", ":", "2", "3", 4'd3));
        request_frame(FUNC_SHOW, pack_item("0", "/", ":", ";", "9", 4'd7));
        request_frame(FUNC_SHOW, pack_item(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 4'd15));
        request_frame(FUNC_SHOW, pack_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd0));
        // Display off, lowest and highest levels, and one just above the top.
        request_frame(FUNC_BRIGHT, pack_item(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 4'd0));
        request_frame(FUNC_BRIGHT, pack_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd1));
        request_frame(FUNC_BRIGHT, pack_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd8));
        request_frame(FUNC_BRIGHT, pack_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 4'd9));
        // Requests while a frame is on the wire are dropped.
        send_item(FUNC_SHOW, pack_item("0", "0", ":", "0", "0", 4'd0));
        repeat (10) tick_once();
        send_item(FUNC_BRIGHT, pack_item("1", "1", "1", "1", "1", 4'd4));
        send_item(FUNC_SHOW, pack_item("2", "2", "2", "2", "2", 4'd4));
        repeat (frame_ticks(FUNC_SHOW, pack_item("0", "0", ":", "0", "0", 4'd0), 0))
            tick_once();

        // Random part at several hold settings. The first one opens with the
        // long result-side stall while items keep coming, and pauses once
        // halfway until everything is back.
        write_wait_ticks(8'd1);
        @(posedge i_clk);
        hold_req = 1'b1;
        run_mixed(125);
        drain();
        run_mixed(125);
        write_wait_ticks(8'd3);
        run_mixed(60);
        // At the top setting a frame cannot finish in this budget; the
        // countdown itself is what gets exercised, and the next phase starts
        // in the middle of that frame.
        write_wait_ticks(8'd255);
        run_mixed(40);
        write_wait_ticks(8'd0);
        run_mixed(120);
        // Last stretch runs at full rate on both sides.
        write_wait_ticks(8'd2);
        idle_on = 1'b0;
        run_mixed(60);

        drain();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        end_check = 1'b1;
        repeat (2) @(negedge i_clk);
        $display("Sent %0d items, checked %0d results: %0d frames started, %0d requests dropped.",
                 items_sent, results_checked, frames_started, requests_dropped);
        $display("Hold settings 5, 0, 1, 3, 255 and 2, with stalls on both sides and one long one.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d failures", fail_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
